[rtl/pgn_pkg.sv]
// ----------------------------------------------------------------------------
// pgn_pkg
// Shared constants and types for the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pgn_pkg;

  localparam int TABLE_SIZE        = 256;
  localparam int TBL_AW            = $clog2(TABLE_SIZE);
  localparam int DEF_FRACTION_BITS = 16;
  localparam int PROD_FRAC         = 40;  // fraction bits of coord * scale
  localparam int OUT_FRAC          = 13;  // fraction bits of the Q2.13 result
  localparam int NUM_STG           = 8;   // pipeline stages ahead of the output word

  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Capture enables, one per pipeline stage
  typedef logic [NUM_STG:1] stage_vec_t;

endpackage

[rtl/pgn_perm_ram.sv]
// ----------------------------------------------------------------------------
// pgn_perm_ram
// One copy of the permutation table: one write port, two registered reads.
// ----------------------------------------------------------------------------
module pgn_perm_ram import pgn_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [TBL_AW-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [TBL_AW-1:0] raddr_a_i,
  input  logic [TBL_AW-1:0] raddr_b_i,
  output logic [7:0]        rdata_a_o,
  output logic [7:0]        rdata_b_o
);

  logic [7:0] mem [TABLE_SIZE];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[rtl/pgn_fade.sv]
// ----------------------------------------------------------------------------
// pgn_fade
// Quintic fade 6t^5-15t^4+10t^3 in Horner form, one multiply per stage,
// two lanes (x and y). Result registered in stage 6.
// ----------------------------------------------------------------------------
module pgn_fade import pgn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk_i,
  input  stage_vec_t               en_i,
  input  logic [FRACTION_BITS-1:0] f_x_i,
  input  logic [FRACTION_BITS-1:0] f_y_i,
  output logic [FRACTION_BITS-1:0] u_o,
  output logic [FRACTION_BITS-1:0] v_o
);

  localparam int F  = FRACTION_BITS;
  localparam int WA = F + 6;
  localparam logic signed [WA-1:0] SIX = WA'(6);
  localparam logic signed [WA-1:0] C15 = WA'(15) << F;
  localparam logic signed [WA-1:0] C10 = WA'(10) << F;

  // floor(f * a / 2^F)
  function automatic logic signed [WA-1:0] fmul(input logic [F-1:0] f,
                                                input logic signed [WA-1:0] a);
    logic signed [F+WA:0] p;
    logic signed [F+WA:0] s;
    p = $signed({1'b0, f}) * a;
    s = p >>> F;
    return s[WA-1:0];
  endfunction

  logic [F-1:0] lane_u [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [F-1:0]          fin;
    logic signed [WA-1:0]  fe;
    logic signed [WA-1:0]  last;
    logic [F-1:0]          f2_q, f3_q, f4_q, f5_q;
    logic signed [WA-1:0]  a2_q, a3_q, a4_q, a5_q;
    logic [F-1:0]          u6_q;

    assign fin  = (l == 0) ? f_x_i : f_y_i;
    assign fe   = $signed({{(WA-F){1'b0}}, fin});
    assign last = fmul(f5_q, a5_q);

    always_ff @(posedge clk_i) begin
      if (en_i[2]) begin
        f2_q <= fin;
        a2_q <= fe * SIX - C15;
      end
      if (en_i[3]) begin
        f3_q <= f2_q;
        a3_q <= fmul(f2_q, a2_q) + C10;
      end
      if (en_i[4]) begin
        f4_q <= f3_q;
        a4_q <= fmul(f3_q, a3_q);
      end
      if (en_i[5]) begin
        f5_q <= f4_q;
        a5_q <= fmul(f4_q, a4_q);
      end
      if (en_i[6]) begin
        u6_q <= last[F-1:0];
      end
    end

    assign lane_u[l] = u6_q;
  end

  assign u_o = lane_u[0];
  assign v_o = lane_u[1];

endmodule

[rtl/pgn_mix.sv]
// ----------------------------------------------------------------------------
// pgn_mix
// Corner gradients, then bilinear blend: x rows in stage 7, y in stage 8.
// ----------------------------------------------------------------------------
module pgn_mix import pgn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                           clk_i,
  input  stage_vec_t                     en_i,
  input  logic [FRACTION_BITS-1:0]       fx_i,
  input  logic [FRACTION_BITS-1:0]       fy_i,
  input  logic [7:0]                     hash_aa_i,
  input  logic [7:0]                     hash_ba_i,
  input  logic [7:0]                     hash_ab_i,
  input  logic [7:0]                     hash_bb_i,
  input  logic [FRACTION_BITS-1:0]       u_i,
  input  logic [FRACTION_BITS-1:0]       v_i,
  output logic signed [FRACTION_BITS+3:0] mix_o
);

  localparam int F  = FRACTION_BITS;
  localparam int GW = F + 4;
  localparam logic signed [GW-1:0] ONE_G = GW'(1) << F;

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [GW-1:0] dx,
                                                input logic signed [GW-1:0] dy);
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = (h < 4'd8) ? dx : dy;
    if (h < 4'd4) begin
      gv = dy;
    end else if (h inside {4'd12, 4'd14}) begin
      gv = dx;
    end else begin
      gv = '0;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  // a + floor(t * (b - a) / 2^F)
  function automatic logic signed [GW-1:0] lerp(input logic [F-1:0] t,
                                                input logic signed [GW-1:0] a,
                                                input logic signed [GW-1:0] b);
    logic signed [GW:0]      d;
    logic signed [F+GW+1:0]  p;
    logic signed [F+GW+1:0]  s;
    d = $signed({b[GW-1], b}) - $signed({a[GW-1], a});
    p = $signed({1'b0, t}) * d;
    s = p >>> F;
    return a + s[GW-1:0];
  endfunction

  logic signed [GW-1:0] dx0, dx1, dy0, dy1;
  logic signed [GW-1:0] g_aa5_q, g_ba5_q, g_ab5_q, g_bb5_q;
  logic signed [GW-1:0] g_aa6_q, g_ba6_q, g_ab6_q, g_bb6_q;
  logic signed [GW-1:0] x1_7_q, x2_7_q;
  logic [F-1:0]         v7_q;
  logic signed [GW-1:0] y8_q;

  assign dx0 = $signed({{(GW-F){1'b0}}, fx_i});
  assign dy0 = $signed({{(GW-F){1'b0}}, fy_i});
  assign dx1 = dx0 - ONE_G;
  assign dy1 = dy0 - ONE_G;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      g_aa5_q <= grad(hash_aa_i[3:0], dx0, dy0);
      g_ba5_q <= grad(hash_ba_i[3:0], dx1, dy0);
      g_ab5_q <= grad(hash_ab_i[3:0], dx0, dy1);
      g_bb5_q <= grad(hash_bb_i[3:0], dx1, dy1);
    end
    if (en_i[6]) begin
      g_aa6_q <= g_aa5_q;
      g_ba6_q <= g_ba5_q;
      g_ab6_q <= g_ab5_q;
      g_bb6_q <= g_bb5_q;
    end
    if (en_i[7]) begin
      x1_7_q <= lerp(u_i, g_aa6_q, g_ba6_q);
      x2_7_q <= lerp(u_i, g_ab6_q, g_bb6_q);
      v7_q   <= v_i;
    end
    if (en_i[8]) begin
      y8_q <= lerp(v7_q, x1_7_q, x2_7_q);
    end
  end

  assign mix_o = y8_q;

endmodule

[rtl/perlin_gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d
// Fixed-point 2D gradient noise, one sample per cycle, nine-stage pipeline.
//
//   channel   dir  tdata (low bit up)                         tuser
//   s_axis    in   coord_x, coord_y, scale_factor,            mode
//                  entry_index, entry_value (104 bits)
//   m_axis    out  noise_value (16 bits)                      -
//
// One word enters per cycle unless stalled; an evaluate word passes eight
// stages and the output register, a load word leaves nothing.
// Throughput is one word per cycle unless stalled: every stage has its own
// multipliers, and the table is held in five copies with two read ports
// each, one for the first lookup level and two for each of the two later levels.
// Each table copy is written when a load word passes the stage that reads it,
// so words in flight see the table exactly as of their own order.
// Reset clears valid and load flags only; the table has no clearing pass.
// A stalled output register holds; empty stages ahead of it keep filling.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d import pgn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] coord_x, [63:32] coord_y, [87:64] scale_factor,
  // [95:88] entry_index, [103:96] entry_value
  input  logic [103:0]  s_axis_tdata,
  // [0] mode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [15:0] noise_value
  output logic [15:0]   m_axis_tdata
);

  localparam int F   = FRACTION_BITS;
  localparam int SW  = F + 8;                // cell index plus fraction
  localparam int GW  = F + 4;
  localparam int QW  = GW + OUT_FRAC + 1;
  localparam int SHL = (F >= OUT_FRAC) ? 0 : OUT_FRAC - F;
  localparam int SHR = (F >= OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam logic signed [QW-1:0] SAT_MAX = QW'(32767);
  localparam logic signed [QW-1:0] SAT_MIN = -QW'(32768);

  // Unpack the input word
  logic signed [31:0] coord_x, coord_y;
  logic [23:0]        scale_factor;
  logic [7:0]         entry_index, entry_value;

  assign coord_x      = s_axis_tdata[31:0];
  assign coord_y      = s_axis_tdata[63:32];
  assign scale_factor = s_axis_tdata[87:64];
  assign entry_index  = s_axis_tdata[95:88];
  assign entry_value  = s_axis_tdata[103:96];

  // Stage control: a stage captures when empty or when the next one captures
  stage_vec_t   en;
  stage_vec_t   v_q, ld_q;
  logic         en_out;
  logic         out_v_q;

  always_comb begin
    en_out = !out_v_q || m_axis_tready;
    en[NUM_STG] = !v_q[NUM_STG] || en_out;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      ld_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[1]) begin
        v_q[1]  <= s_axis_tvalid;
        ld_q[1] <= (s_axis_tuser == MODE_LOAD);
      end
      for (int k = 2; k <= NUM_STG; k++) begin
        if (en[k]) begin
          v_q[k]  <= v_q[k-1];
          ld_q[k] <= ld_q[k-1];
        end
      end
      if (en_out) begin
        out_v_q <= v_q[NUM_STG] && !ld_q[NUM_STG];
      end
    end
  end

  // Stage 1: scale the coordinates, keep cell index and fraction bits
  logic signed [56:0] prod_x, prod_y;
  logic [SW-1:0]      px1_q, py1_q;
  logic [7:0]         idx1_q, val1_q, idx2_q, val2_q, idx3_q, val3_q;

  assign prod_x = coord_x * $signed({1'b0, scale_factor});
  assign prod_y = coord_y * $signed({1'b0, scale_factor});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px1_q  <= prod_x[PROD_FRAC+7:PROD_FRAC-F];
      py1_q  <= prod_y[PROD_FRAC+7:PROD_FRAC-F];
      idx1_q <= entry_index;
      val1_q <= entry_value;
    end
  end

  logic [7:0]   ix1, iy1;
  logic [F-1:0] fx1, fy1;

  assign ix1 = px1_q[SW-1:F];
  assign iy1 = py1_q[SW-1:F];
  assign fx1 = px1_q[F-1:0];
  assign fy1 = py1_q[F-1:0];

  // Stage 2: first lookup level, p[ix] and p[ix+1]
  logic [7:0]   iy2_q;
  logic [F-1:0] fx2_q, fy2_q, fx3_q, fy3_q, fx4_q, fy4_q;
  logic [7:0]   rd0a, rd0b;

  pgn_perm_ram u_ram0 (
    .clk_i     (clk_i),
    .we_i      (en[2] && v_q[1] && ld_q[1]),
    .waddr_i   (idx1_q),
    .wdata_i   (val1_q),
    .re_i      (en[2]),
    .raddr_a_i (ix1),
    .raddr_b_i (ix1 + 8'd1),
    .rdata_a_o (rd0a),
    .rdata_b_o (rd0b)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      iy2_q  <= iy1;
      fx2_q  <= fx1;
      fy2_q  <= fy1;
      idx2_q <= idx1_q;
      val2_q <= val1_q;
    end
    if (en[3]) begin
      fx3_q  <= fx2_q;
      fy3_q  <= fy2_q;
      idx3_q <= idx2_q;
      val3_q <= val2_q;
    end
    if (en[4]) begin
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
    end
  end

  // Stage 3: second level at ha, ha+1 and hb, hb+1 (wrap mod 256)
  logic [7:0] ha2, hb2;
  logic [7:0] rd1a, rd1b, rd2a, rd2b;

  assign ha2 = rd0a + iy2_q;
  assign hb2 = rd0b + iy2_q;

  pgn_perm_ram u_ram1 (
    .clk_i     (clk_i),
    .we_i      (en[3] && v_q[2] && ld_q[2]),
    .waddr_i   (idx2_q),
    .wdata_i   (val2_q),
    .re_i      (en[3]),
    .raddr_a_i (ha2),
    .raddr_b_i (ha2 + 8'd1),
    .rdata_a_o (rd1a),
    .rdata_b_o (rd1b)
  );

  pgn_perm_ram u_ram2 (
    .clk_i     (clk_i),
    .we_i      (en[3] && v_q[2] && ld_q[2]),
    .waddr_i   (idx2_q),
    .wdata_i   (val2_q),
    .re_i      (en[3]),
    .raddr_a_i (hb2),
    .raddr_b_i (hb2 + 8'd1),
    .rdata_a_o (rd2a),
    .rdata_b_o (rd2b)
  );

  // Stage 4: extra lookup level ahead of the gradients
  logic [7:0] rd3a, rd3b, rd4a, rd4b;

  pgn_perm_ram u_ram3 (
    .clk_i     (clk_i),
    .we_i      (en[4] && v_q[3] && ld_q[3]),
    .waddr_i   (idx3_q),
    .wdata_i   (val3_q),
    .re_i      (en[4]),
    .raddr_a_i (rd1a),
    .raddr_b_i (rd2a),
    .rdata_a_o (rd3a),
    .rdata_b_o (rd3b)
  );

  pgn_perm_ram u_ram4 (
    .clk_i     (clk_i),
    .we_i      (en[4] && v_q[3] && ld_q[3]),
    .waddr_i   (idx3_q),
    .wdata_i   (val3_q),
    .re_i      (en[4]),
    .raddr_a_i (rd1b),
    .raddr_b_i (rd2b),
    .rdata_a_o (rd4a),
    .rdata_b_o (rd4b)
  );

  // Fade runs alongside the hash chain, stages 2 to 6
  logic [F-1:0] fade_u, fade_v;

  pgn_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade (
    .clk_i (clk_i),
    .en_i  (en),
    .f_x_i (fx1),
    .f_y_i (fy1),
    .u_o   (fade_u),
    .v_o   (fade_v)
  );

  // Stages 5 to 8: gradients and blend
  logic signed [GW-1:0] mix;

  pgn_mix #(.FRACTION_BITS(FRACTION_BITS)) u_mix (
    .clk_i     (clk_i),
    .en_i      (en),
    .fx_i      (fx4_q),
    .fy_i      (fy4_q),
    .hash_aa_i (rd3a),
    .hash_ba_i (rd3b),
    .hash_ab_i (rd4a),
    .hash_bb_i (rd4b),
    .u_i       (fade_u),
    .v_i       (fade_v),
    .mix_o     (mix)
  );

  // Output register: move to Q2.13 (floor), saturate
  logic signed [QW-1:0] r_ext, q_ext;
  logic [15:0]          noise_d, noise_q;

  always_comb begin
    r_ext = $signed({{(QW-GW){mix[GW-1]}}, mix});
    q_ext = (r_ext <<< SHL) >>> SHR;
    if (q_ext > SAT_MAX) begin
      noise_d = 16'h7FFF;
    end else if (q_ext < SAT_MIN) begin
      noise_d = 16'h8000;
    end else begin
      noise_d = q_ext[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      noise_q <= noise_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = noise_q;

`ifndef SYNTHESIS
  // A load word reaching the end never shows up as a result
  a_load_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out && v_q[NUM_STG] && ld_q[NUM_STG] |=> !m_axis_tvalid)
    else $error("load word produced an output");

  // An evaluate word reaching the end always becomes a result
  a_eval_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out && v_q[NUM_STG] && !ld_q[NUM_STG] |=> m_axis_tvalid)
    else $error("evaluate word lost at output");

  // Input is refused only when the whole pipe is backed up by the sink
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && (&v_q))
    else $error("input stalled without back pressure");

  // A held stage keeps its word
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en[1] && v_q[1] |=> v_q[1] && $stable(px1_q))
    else $error("stalled stage lost its word");
`endif

endmodule

[tb/perlin_gradient_noise_2d_chk.sv]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_chk
// Watches both stream channels, predicts each noise word from its own copy of
// the permutation table and compares it with the word the block emits.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d_chk import pgn_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           noise_cnt_o
);

  localparam longint ONE = longint'(1) << FRACTION_BITS;

  logic [7:0]  perm_copy [TABLE_SIZE];
  logic [15:0] noise_q [$];

  function automatic longint fade(longint t);
    longint a;
    a = t * 6 - 15 * ONE;
    a = ((t * a) >>> FRACTION_BITS) + 10 * ONE;
    a = (t * a) >>> FRACTION_BITS;
    a = (t * a) >>> FRACTION_BITS;
    return (t * a) >>> FRACTION_BITS;
  endfunction

  function automatic longint mix(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> FRACTION_BITS);
  endfunction

  function automatic longint grad(logic [7:0] hash, longint dx, longint dy);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? dx : dy;
    v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] look(int i);
    return perm_copy[i & 255];
  endfunction

  function automatic logic [15:0] noise_of(logic [103:0] w);
    longint px, py, fx, fy, u, v, r, q;
    int ix, iy, ha, hb;
    px = longint'($signed(w[31:0])) * longint'({1'b0, w[87:64]});
    py = longint'($signed(w[63:32])) * longint'({1'b0, w[87:64]});
    ix = int'(px[47:40]);
    iy = int'(py[47:40]);
    fx = (px >>> (PROD_FRAC - FRACTION_BITS)) & (ONE - 1);
    fy = (py >>> (PROD_FRAC - FRACTION_BITS)) & (ONE - 1);
    u = fade(fx);
    v = fade(fy);
    ha = (look(ix) + iy) & 255;
    hb = (look(ix + 1) + iy) & 255;
    r = mix(v,
      mix(u, grad(look(look(ha)), fx, fy), grad(look(look(hb)), fx - ONE, fy)),
      mix(u, grad(look(look(ha + 1)), fx, fy - ONE),
        grad(look(look(hb + 1)), fx - ONE, fy - ONE)));
    if (FRACTION_BITS >= OUT_FRAC) q = r >>> (FRACTION_BITS - OUT_FRAC);
    else q = r * (longint'(1) << (OUT_FRAC - FRACTION_BITS));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // predict from the table as of this word's position in the stream
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_LOAD) perm_copy[s_axis_tdata[95:88]] = s_axis_tdata[103:96];
        else noise_q.push_back(noise_of(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        noise_cnt_o++;
        if (noise_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected noise word, actual %h", $time, m_axis_tdata);
        end else begin
          if (noise_q[0] !== m_axis_tdata) begin
            fail_cnt_o++;
            $display("%0t: noise_value expected %h actual %h", $time, noise_q[0],
              m_axis_tdata);
          end
          void'(noise_q.pop_front());
        end
      end
      pending_o = noise_q.size();
    end
  end

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
    noise_cnt_o = 0;
  end

endmodule

[tb/perlin_gradient_noise_2d_tb.sv]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_tb
// Loads the permutation table, then streams directed and random evaluate
// words under changing backpressure with occasional table rewrites.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d_tb;
  import pgn_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = MODE_EVAL;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  int           fail_cnt, pending, noise_cnt;
  int           src_idle_pct = 0, snk_stall_pct = 0;
  bit           hold_off = 1'b0;
  int           quiet_cycles = 0;
  int           words_sent = 0;

  always #5 clk_i = ~clk_i;

  perlin_gradient_noise_2d dut (.*);

  perlin_gradient_noise_2d_chk chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .noise_cnt_o(noise_cnt)
  );

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // offer one word, with a random idle gap first; hold it until accepted,
  // return at the falling edge after acceptance with valid still raised
  task automatic send_word(logic mode, logic [103:0] w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic load_entry(logic [7:0] idx, logic [7:0] val);
    send_word(MODE_LOAD, {val, idx, 24'h0, 64'h0});
  endtask

  task automatic eval_point(logic [31:0] x, logic [31:0] y, logic [23:0] s);
    send_word(MODE_EVAL, {16'($urandom()), s, y, x});
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
      2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return {8'($urandom()) , 24'($urandom())} >>> $urandom_range(16);
    endcase
  endfunction

  function automatic logic [23:0] rnd_scale();
    case ($urandom_range(3))
      0: return 24'hff_ffff;
      1: return 24'($urandom()) >> $urandom_range(20);
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    logic [7:0] shuffle [256];
    logic [7:0] tmp;
    int j;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // full table as a shuffled permutation, extremes included
    for (int i = 0; i < 256; i++) shuffle[i] = i[7:0];
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = shuffle[i]; shuffle[i] = shuffle[j]; shuffle[j] = tmp;
    end
    for (int i = 0; i < 256; i++) load_entry(i[7:0], shuffle[i]);

    // directed: field extremes and edge scales
    eval_point(32'h0, 32'h0, 24'h0);
    eval_point(32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff);
    eval_point(32'h8000_0000, 32'h8000_0000, 24'hff_ffff);
    eval_point(32'h7fff_ffff, 32'h8000_0000, 24'h80_0000);
    eval_point(32'hffff_ffff, 32'h0001_0000, 24'hff_ffff);
    eval_point(32'h0000_8000, 32'hffff_8000, 24'h00_0001);
    eval_point(32'h0001_0000, 32'h0001_0000, 24'hff_ffff);
    eval_point(32'h00ff_ffff, 32'hff00_0001, 24'hff_ffff);
    load_entry(8'h00, 8'hff);
    load_entry(8'hff, 8'h00);
    eval_point(32'h0000_0000, 32'h00ff_0000, 24'hff_ffff);
    eval_point(32'h5555_5555, 32'haaaa_aaaa, 24'h55_5555);
    eval_point(32'haaaa_aaaa, 32'h5555_5555, 24'haa_aaaa);

    // random phases with varied idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 81; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 81; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      for (int k = 0; k < 370; k++) begin
        if ($urandom_range(19) == 0) load_entry(8'($urandom()), 8'($urandom()));
        else eval_point(rnd_coord(), rnd_coord(), rnd_scale());
      end
      // long hold-off so the pipeline fills and backs up into the input
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(negedge clk_i);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 30; k++)
            eval_point(rnd_coord(), rnd_coord(), rnd_scale());
        join
      end
    end

    // drop valid once the last word is taken
    s_axis_tvalid <= 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d words (table loads and evaluations), checked %0d noise words.",
      words_sent, noise_cnt);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
